// ===== sv/hrfe_pkg.sv =====
// hrfe_pkg: shared types and constants of the hart request frame encoder
// no dependencies; imported by every module of the block
package hrfe_pkg;

   localparam logic [7:0] PREAMBLE_BYTE = 8'hFF;
   localparam logic [4:0] MAX_PREAMBLES = 5'd23;
   localparam logic [7:0] DELIM_STX     = 8'h02;
   localparam logic [7:0] DELIM_BACK    = 8'h01;
   localparam logic [7:0] LONG_FLAG     = 8'h80;
   localparam logic [7:0] ADDR_MASK     = 8'h3F;
   localparam logic [2:0] LAST_ADDR_LONG  = 3'd4;
   localparam logic [2:0] LAST_ADDR_SHORT = 3'd0;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   localparam logic [2:0] REG_PREAMBLE_COUNT = 3'd0;
   localparam logic [2:0] REG_LONG_ADDRESS   = 3'd1;
   localparam logic [2:0] REG_SHORT_ADDRESS  = 3'd2;
   localparam logic [2:0] REG_UNIQUE_ID      = 3'd3;
   localparam logic [2:0] REG_COMMAND_CODE   = 3'd4;
   localparam logic [2:0] REG_PRIMARY_MASTER = 3'd5;
   localparam logic [2:0] REG_BURST_FRAME    = 3'd6;
   localparam logic [2:0] REG_PAYLOAD_LENGTH = 3'd7;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic       cmd;
      logic [7:0] payload_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_done;
   } rsp_word_type;

   typedef struct packed {
      logic [4:0]  preamble_count;
      logic        long_address;
      logic [7:0]  short_address;
      logic [39:0] unique_id;
      logic [7:0]  command_code;
      logic        primary_master;
      logic        burst_frame;
      logic [7:0]  payload_length;
   } cfg_type;

   typedef struct packed {
      logic       is_start;
      logic [7:0] data;
      logic       last;
   } op_type;

endpackage

// ===== sv/hrfe_csr.sv =====
// hrfe_csr: apb-style configuration register file
// depends on hrfe_pkg
module hrfe_csr import hrfe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] index;
   logic       wr_en;

   assign index  = paddr[CSR_ADDR_W-1:3];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_PREAMBLE_COUNT: cfg_in.preamble_count = pwdata[4:0];
            REG_LONG_ADDRESS:   cfg_in.long_address   = pwdata[0];
            REG_SHORT_ADDRESS:  cfg_in.short_address  = pwdata[7:0];
            REG_UNIQUE_ID:      cfg_in.unique_id      = pwdata[39:0];
            REG_COMMAND_CODE:   cfg_in.command_code   = pwdata[7:0];
            REG_PRIMARY_MASTER: cfg_in.primary_master = pwdata[0];
            REG_BURST_FRAME:    cfg_in.burst_frame    = pwdata[0];
            REG_PAYLOAD_LENGTH: cfg_in.payload_length = pwdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_PREAMBLE_COUNT: prdata = {59'd0, cfg_ff.preamble_count};
         REG_LONG_ADDRESS:   prdata = {63'd0, cfg_ff.long_address};
         REG_SHORT_ADDRESS:  prdata = {56'd0, cfg_ff.short_address};
         REG_UNIQUE_ID:      prdata = {24'd0, cfg_ff.unique_id};
         REG_COMMAND_CODE:   prdata = {56'd0, cfg_ff.command_code};
         REG_PRIMARY_MASTER: prdata = {63'd0, cfg_ff.primary_master};
         REG_BURST_FRAME:    prdata = {63'd0, cfg_ff.burst_frame};
         REG_PAYLOAD_LENGTH: prdata = {56'd0, cfg_ff.payload_length};
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff                <= '0;
         cfg_ff.preamble_count <= 5'd5;
         cfg_ff.primary_master <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/hrfe_front.sv =====
// hrfe_front: accepts request words, tracks frame state, classifies into ops
// depends on hrfe_pkg
module hrfe_front import hrfe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  req_word_type req_word,
   input  cfg_type      cfg,
   input  logic         q_full,
   output logic         full,
   output logic         q_push,
   output op_type       q_op
);

   logic       in_frame_ff, in_frame_in;
   logic [7:0] remain_ff, remain_in;
   logic       accept;

   assign full   = q_full;
   assign accept = push & ~q_full;

   always_comb begin
      in_frame_in     = in_frame_ff;
      remain_in       = remain_ff;
      q_push          = 1'b0;
      q_op.is_start   = (req_word.cmd == CMD_START);
      q_op.data       = req_word.payload_byte;
      q_op.last       = (remain_ff == 8'd1);
      if (accept) begin
         if (req_word.cmd == CMD_START) begin
            q_push      = 1'b1;
            remain_in   = cfg.payload_length;
            in_frame_in = (cfg.payload_length != 8'd0);
         end else if (in_frame_ff) begin
            q_push      = 1'b1;
            remain_in   = remain_ff - 8'd1;
            in_frame_in = (remain_ff != 8'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         remain_ff   <= 8'd0;
      end else begin
         in_frame_ff <= in_frame_in;
         remain_ff   <= remain_in;
      end
   end

endmodule

// ===== sv/hrfe_queue.sv =====
// hrfe_queue: short op queue between front and back
// depends on hrfe_pkg
module hrfe_queue import hrfe_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   wr_en,
   input  op_type wr_op,
   input  logic   rd_en,
   output op_type rd_op,
   output logic   q_full,
   output logic   q_empty
);

   op_type                 entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   assign q_full  = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign rd_op   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_ptr_ff] <= wr_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !wr_en || rd_en)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> !rd_en)
      else $error("queue read while empty");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (wr_en && !rd_en) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count out of step");

endmodule

// ===== sv/hrfe_back.sv =====
// hrfe_back: frame sequencer, emits header, payload and checksum words
// depends on hrfe_pkg
module hrfe_back import hrfe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  op_type       q_head,
   input  logic         q_empty,
   output logic         q_pop,
   input  logic         pop,
   output logic         empty,
   output rsp_word_type rsp_word
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PRE   = 3'd1;
   localparam logic [2:0] ST_DELIM = 3'd2;
   localparam logic [2:0] ST_ADDR  = 3'd3;
   localparam logic [2:0] ST_CMD   = 3'd4;
   localparam logic [2:0] ST_LEN   = 3'd5;
   localparam logic [2:0] ST_SUM   = 3'd6;

   logic [2:0]   state_ff, state_in;
   logic [4:0]   pre_cnt_ff, pre_cnt_in;
   logic [2:0]   idx_ff, idx_in;
   logic [7:0]   sum_ff, sum_in;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_ff, out_in;

   logic         emit_ok, emit;
   rsp_word_type word;
   logic [4:0]   pre_sat;
   logic [7:0]   delim;
   logic [7:0]   addr_byte;
   logic [7:0]   first_byte;
   logic [2:0]   last_idx;

   assign emit_ok  = ~out_valid_ff | pop;
   assign empty    = ~out_valid_ff;
   assign rsp_word = out_ff;
   assign pre_sat  = (cfg.preamble_count > MAX_PREAMBLES) ? MAX_PREAMBLES : cfg.preamble_count;
   assign delim    = (cfg.burst_frame ? DELIM_BACK : DELIM_STX)
                   | (cfg.long_address ? LONG_FLAG : 8'h00);
   assign last_idx = cfg.long_address ? LAST_ADDR_LONG : LAST_ADDR_SHORT;

   always_comb begin
      first_byte    = (cfg.long_address ? cfg.unique_id[39:32] : cfg.short_address) & ADDR_MASK;
      first_byte[7] = cfg.primary_master;
      first_byte[6] = cfg.burst_frame;
      case (idx_ff)
         3'd1:    addr_byte = cfg.unique_id[31:24];
         3'd2:    addr_byte = cfg.unique_id[23:16];
         3'd3:    addr_byte = cfg.unique_id[15:8];
         3'd4:    addr_byte = cfg.unique_id[7:0];
         default: addr_byte = first_byte;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      pre_cnt_in = pre_cnt_ff;
      idx_in     = idx_ff;
      sum_in     = sum_ff;
      q_pop      = 1'b0;
      emit       = 1'b0;
      word       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               if (q_head.is_start) begin
                  q_pop      = 1'b1;
                  pre_cnt_in = pre_sat;
                  state_in   = (pre_sat == 5'd0) ? ST_DELIM : ST_PRE;
               end else if (emit_ok) begin
                  q_pop         = 1'b1;
                  emit          = 1'b1;
                  word.out_byte = q_head.data;
                  word.run_last = ~q_head.last;
                  sum_in        = sum_ff ^ q_head.data;
                  state_in      = q_head.last ? ST_SUM : ST_IDLE;
               end
            end
         end
         ST_PRE: begin
            if (emit_ok) begin
               emit          = 1'b1;
               word.out_byte = PREAMBLE_BYTE;
               pre_cnt_in    = pre_cnt_ff - 5'd1;
               if (pre_cnt_ff == 5'd1) begin
                  state_in = ST_DELIM;
               end
            end
         end
         ST_DELIM: begin
            if (emit_ok) begin
               emit          = 1'b1;
               word.out_byte = delim;
               sum_in        = delim;
               idx_in        = 3'd0;
               state_in      = ST_ADDR;
            end
         end
         ST_ADDR: begin
            if (emit_ok) begin
               emit          = 1'b1;
               word.out_byte = addr_byte;
               sum_in        = sum_ff ^ addr_byte;
               idx_in        = idx_ff + 3'd1;
               if (idx_ff == last_idx) begin
                  state_in = ST_CMD;
               end
            end
         end
         ST_CMD: begin
            if (emit_ok) begin
               emit          = 1'b1;
               word.out_byte = cfg.command_code;
               sum_in        = sum_ff ^ cfg.command_code;
               state_in      = ST_LEN;
            end
         end
         ST_LEN: begin
            if (emit_ok) begin
               emit          = 1'b1;
               word.out_byte = cfg.payload_length;
               word.run_last = (cfg.payload_length != 8'd0);
               sum_in        = sum_ff ^ cfg.payload_length;
               state_in      = (cfg.payload_length == 8'd0) ? ST_SUM : ST_IDLE;
            end
         end
         ST_SUM: begin
            if (emit_ok) begin
               emit            = 1'b1;
               word.out_byte   = sum_ff;
               word.run_last   = 1'b1;
               word.frame_done = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff & ~pop;
      if (emit) begin
         out_in       = word;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      out_ff     <= out_in;
      pre_cnt_ff <= pre_cnt_in;
      idx_ff     <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.frame_done) |-> out_ff.run_last)
      else $error("checksum word not marked last");

   a_pop_in_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE)
      else $error("op taken while sequencer busy");

   a_pre_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PRE |-> pre_cnt_ff != 5'd0)
      else $error("preamble state with zero count");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> state_ff == ST_IDLE && !out_valid_ff)
      else $error("sequencer not idle after reset");

endmodule

// ===== sv/hart_request_frame_encoder_core.sv =====
// hart_request_frame_encoder_core: top level of the hart request frame encoder
// depends on hrfe_pkg, hrfe_csr, hrfe_front, hrfe_queue, hrfe_back
//
// channel   ports                               handshake
// request   push, full, req_word                push & !full
// response  empty, pop, rsp_word                pop & !empty
// config    psel penable pwrite paddr pwdata    psel & penable & pwrite
//           prdata pready                       (pready always high)
//
// a payload word gives one response word, plus the checksum word on the last one
// a start word is loaded first, then its header words follow one by one from
// the single back-end sequencer and its output register, as pop frees that register
// a four-entry op queue lets the front keep accepting while the back stalls
// synchronous active-high reset; no clearing pass
module hart_request_frame_encoder_core import hrfe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  req_word_type          req_word,
   output logic                  empty,
   input  logic                  pop,
   output rsp_word_type          rsp_word,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type cfg;
   logic    q_push, q_pop, q_full, q_empty;
   op_type  q_op, q_head;

   hrfe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hrfe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_word (req_word),
      .cfg      (cfg),
      .q_full   (q_full),
      .full     (full),
      .q_push   (q_push),
      .q_op     (q_op)
   );

   hrfe_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_op   (q_op),
      .rd_en   (q_pop),
      .rd_op   (q_head),
      .q_full  (q_full),
      .q_empty (q_empty)
   );

   hrfe_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_head   (q_head),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_word (rsp_word)
   );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for hart_request_frame_encoder_core, top module last
// builds every frame word in its own encoder model and checks the response words in order
// depends on hrfe_pkg and the encoder rtl
module testbench;
   import hrfe_pkg::*;

   localparam logic [7:0] FILL_BYTE   = 8'hFF;
   localparam logic [4:0] PRE_CAP     = 5'd23;
   localparam logic [7:0] START_DELIM = 8'h02;
   localparam logic [7:0] BURST_DELIM = 8'h01;
   localparam logic [7:0] LONG_BIT    = 8'h80;
   localparam logic [7:0] MASTER_BIT  = 8'h80;
   localparam logic [7:0] BURST_BIT   = 8'h40;
   localparam logic [7:0] ADDR_BITS   = 8'h3F;
   localparam int         SETTLE      = 64;
   localparam int         REPORT_MAX  = 10;

   logic                  clock;
   logic                  reset    = 1'b1;
   logic                  push     = 1'b0;
   logic                  full;
   req_word_type          req_word = '0;
   logic                  empty;
   logic                  pop      = 1'b0;
   rsp_word_type          rsp_word;
   logic                  psel     = 1'b0;
   logic                  penable  = 1'b0;
   logic                  pwrite   = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr    = '0;
   logic [CSR_DATA_W-1:0] pwdata   = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   cfg_type      shadow_cfg;
   logic [7:0]   frame_sum;
   logic [7:0]   bytes_left;
   logic         frame_open;
   rsp_word_type frame_bytes[$];
   int           words_added;

   bit push_on  = 1'b0;
   bit pop_on   = 1'b0;
   bit idle_off = 1'b0;
   int hold_request = 0;
   int mismatches   = 0;
   int items_sent   = 0;
   int active_items = 0;
   int words_seen   = 0;
   int frames_seen  = 0;
   int csr_writes   = 0;
   int csr_reads    = 0;

   hart_request_frame_encoder_core DUT (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .req_word(req_word),
      .empty   (empty),
      .pop     (pop),
      .rsp_word(rsp_word),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("FAIL hart_request_frame_encoder_core");
      $finish;
   end

   function automatic void add_byte(input logic [7:0] b, input bit fold, input bit done);
      rsp_word_type r;
      r.out_byte   = b;
      r.run_last   = 1'b0;
      r.frame_done = done;
      frame_bytes.push_back(r);
      if (fold) frame_sum = frame_sum ^ b;
      words_added++;
   endfunction

   function automatic void close_frame();
      add_byte(frame_sum, 1'b0, 1'b1);
      frame_open = 1'b0;
      bytes_left = '0;
   endfunction

   function automatic void encode_request(input req_word_type w);
      logic [4:0] pre;
      logic [7:0] delim;
      logic [7:0] first;
      words_added = 0;
      if (w.cmd == CMD_START) begin
         pre = (shadow_cfg.preamble_count > PRE_CAP) ? PRE_CAP : shadow_cfg.preamble_count;
         repeat (pre) add_byte(FILL_BYTE, 1'b0, 1'b0);
         frame_sum = '0;
         delim = shadow_cfg.burst_frame ? BURST_DELIM : START_DELIM;
         if (shadow_cfg.long_address) delim = delim | LONG_BIT;
         add_byte(delim, 1'b1, 1'b0);
         first = shadow_cfg.long_address ? shadow_cfg.unique_id[39:32]
                                         : shadow_cfg.short_address;
         first = first & ADDR_BITS;
         if (shadow_cfg.primary_master) first = first | MASTER_BIT;
         if (shadow_cfg.burst_frame) first = first | BURST_BIT;
         add_byte(first, 1'b1, 1'b0);
         if (shadow_cfg.long_address) begin
            for (int k = 3; k >= 0; k--) add_byte(shadow_cfg.unique_id[8*k +: 8], 1'b1, 1'b0);
         end
         add_byte(shadow_cfg.command_code, 1'b1, 1'b0);
         add_byte(shadow_cfg.payload_length, 1'b1, 1'b0);
         bytes_left = shadow_cfg.payload_length;
         frame_open = 1'b1;
         if (bytes_left == 8'd0) close_frame();
      end else if (frame_open) begin
         add_byte(w.payload_byte, 1'b1, 1'b0);
         bytes_left = bytes_left - 8'd1;
         if (bytes_left == 8'd0) close_frame();
      end
      if (words_added > 0) frame_bytes[frame_bytes.size()-1].run_last = 1'b1;
   endfunction

   function automatic void set_shadow(input logic [2:0] idx, input logic [63:0] value);
      case (idx)
         REG_PREAMBLE_COUNT: shadow_cfg.preamble_count = value[4:0];
         REG_LONG_ADDRESS:   shadow_cfg.long_address   = value[0];
         REG_SHORT_ADDRESS:  shadow_cfg.short_address  = value[7:0];
         REG_UNIQUE_ID:      shadow_cfg.unique_id      = value[39:0];
         REG_COMMAND_CODE:   shadow_cfg.command_code   = value[7:0];
         REG_PRIMARY_MASTER: shadow_cfg.primary_master = value[0];
         REG_BURST_FRAME:    shadow_cfg.burst_frame    = value[0];
         REG_PAYLOAD_LENGTH: shadow_cfg.payload_length = value[7:0];
         default: ;
      endcase
   endfunction

   function automatic logic [63:0] shadow_value(input logic [2:0] idx);
      logic [63:0] v;
      v = '0;
      case (idx)
         REG_PREAMBLE_COUNT: v[4:0]  = shadow_cfg.preamble_count;
         REG_LONG_ADDRESS:   v[0]    = shadow_cfg.long_address;
         REG_SHORT_ADDRESS:  v[7:0]  = shadow_cfg.short_address;
         REG_UNIQUE_ID:      v[39:0] = shadow_cfg.unique_id;
         REG_COMMAND_CODE:   v[7:0]  = shadow_cfg.command_code;
         REG_PRIMARY_MASTER: v[0]    = shadow_cfg.primary_master;
         REG_BURST_FRAME:    v[0]    = shadow_cfg.burst_frame;
         REG_PAYLOAD_LENGTH: v[7:0]  = shadow_cfg.payload_length;
         default: ;
      endcase
      return v;
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      set_shadow(idx, value);
      csr_writes++;
   endtask

   task automatic csr_check(input logic [2:0] idx);
      logic [63:0] want;
      want = shadow_value(idx);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 3'b000};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("register %0d: expected %016h, got %016h", idx, want, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      csr_reads++;
   endtask

   task automatic send_word(input logic c, input logic [7:0] b);
      int           gap;
      req_word_type w;
      gap = idle_off ? 0 : $urandom_range(14, 0);
      w.cmd = c;
      w.payload_byte = b;
      if (gap > 0 && push_on) begin
         push    <= 1'b0;
         push_on  = 1'b0;
      end
      repeat (gap) @(posedge clock);
      req_word <= w;
      if (!push_on) begin
         push    <= 1'b1;
         push_on  = 1'b1;
      end
      do @(posedge clock); while (full);
      encode_request(w);
      items_sent++;
      if (words_added > 0) active_items++;
   endtask

   task automatic wait_drained();
      if (push_on) begin
         push    <= 1'b0;
         push_on  = 1'b0;
         @(posedge clock);
      end
      while (frame_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin : response_checker
      int           stall;
      rsp_word_type want;
      while (reset) @(posedge clock);
      forever begin
         stall = idle_off ? 0 : $urandom_range(14, 0);
         if (hold_request > 0) begin
            stall = hold_request;
            hold_request = 0;
         end
         if (stall > 0 && pop_on) begin
            pop    <= 1'b0;
            pop_on  = 1'b0;
         end
         repeat (stall) @(posedge clock);
         if (!pop_on) begin
            pop    <= 1'b1;
            pop_on  = 1'b1;
         end
         do @(posedge clock); while (empty);
         words_seen++;
         if (rsp_word.frame_done) frames_seen++;
         if (frame_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected word: byte %02h last %0b done %0b", rsp_word.out_byte,
                        rsp_word.run_last, rsp_word.frame_done);
         end else begin
            want = frame_bytes.pop_front();
            if (rsp_word.out_byte !== want.out_byte || rsp_word.run_last !== want.run_last ||
                rsp_word.frame_done !== want.frame_done) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("word %0d: expected byte %02h last %0b done %0b, %s %02h %s %0b %s %0b",
                           words_seen, want.out_byte, want.run_last, want.frame_done,
                           "got byte", rsp_word.out_byte, "last", rsp_word.run_last,
                           "done", rsp_word.frame_done);
            end
         end
      end
   end

   task automatic test_reset_defaults();
      send_word(CMD_DATA, 8'h5A);
      send_word(CMD_START, 8'h00);
      send_word(CMD_DATA, 8'hFF);
      wait_drained();
   endtask

   task automatic test_register_readback();
      for (int i = 0; i < 8; i++) csr_check(3'(i));
   endtask

   task automatic test_short_address();
      csr_write(REG_PREAMBLE_COUNT, 64'd0);
      csr_write(REG_LONG_ADDRESS, 64'd0);
      csr_write(REG_SHORT_ADDRESS, 64'hFF);
      csr_write(REG_COMMAND_CODE, 64'hFF);
      csr_write(REG_PRIMARY_MASTER, 64'd0);
      csr_write(REG_BURST_FRAME, 64'd1);
      csr_write(REG_PAYLOAD_LENGTH, 64'd2);
      send_word(CMD_START, 8'hFF);
      send_word(CMD_DATA, 8'h00);
      send_word(CMD_DATA, 8'hFF);
      wait_drained();
   endtask

   task automatic test_long_address();
      csr_write(REG_PREAMBLE_COUNT, 64'd31);
      csr_write(REG_LONG_ADDRESS, 64'd1);
      csr_write(REG_UNIQUE_ID, 64'hFF_FFFF_FFFF);
      csr_write(REG_COMMAND_CODE, 64'h00);
      csr_write(REG_PRIMARY_MASTER, 64'd1);
      csr_write(REG_BURST_FRAME, 64'd0);
      csr_write(REG_PAYLOAD_LENGTH, 64'd1);
      send_word(CMD_START, 8'h00);
      send_word(CMD_DATA, 8'hA5);
      wait_drained();
      csr_write(REG_PREAMBLE_COUNT, 64'd23);
      csr_write(REG_UNIQUE_ID, 64'd0);
      csr_write(REG_BURST_FRAME, 64'd1);
      csr_write(REG_PRIMARY_MASTER, 64'd0);
      csr_write(REG_PAYLOAD_LENGTH, 64'd0);
      send_word(CMD_START, 8'h3C);
      wait_drained();
   endtask

   task automatic test_restart_in_frame();
      csr_write(REG_PREAMBLE_COUNT, 64'd1);
      csr_write(REG_LONG_ADDRESS, 64'd0);
      csr_write(REG_SHORT_ADDRESS, 64'h2A);
      csr_write(REG_BURST_FRAME, 64'd0);
      csr_write(REG_PAYLOAD_LENGTH, 64'd255);
      send_word(CMD_START, 8'h00);
      send_word(CMD_DATA, 8'h01);
      send_word(CMD_DATA, 8'h80);
      send_word(CMD_START, 8'hC3);
      send_word(CMD_DATA, 8'h7F);
      wait_drained();
   endtask

   task automatic test_length_latch();
      csr_write(REG_PAYLOAD_LENGTH, 64'd3);
      send_word(CMD_START, 8'h00);
      send_word(CMD_DATA, 8'h11);
      wait_drained();
      csr_write(REG_PAYLOAD_LENGTH, 64'd7);
      csr_write(REG_COMMAND_CODE, 64'h55);
      send_word(CMD_DATA, 8'h22);
      send_word(CMD_DATA, 8'h33);
      send_word(CMD_DATA, 8'h44);
      wait_drained();
   endtask

   task automatic test_backpressure();
      csr_write(REG_PREAMBLE_COUNT, 64'd5);
      csr_write(REG_LONG_ADDRESS, 64'd0);
      csr_write(REG_PAYLOAD_LENGTH, 64'd20);
      hold_request = 300;
      idle_off = 1'b1;
      send_word(CMD_START, 8'h00);
      repeat (20) send_word(CMD_DATA, 8'($urandom));
      idle_off = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_frames();
      int          target;
      int          n;
      logic [7:0]  len;
      logic [4:0]  pre;
      target = active_items + 110;
      while (active_items < target) begin
         idle_off = ($urandom_range(3, 0) == 0);
         case ($urandom_range(3, 0))
            0:       pre = 5'd0;
            1:       pre = 5'd31;
            default: pre = 5'($urandom_range(31, 0));
         endcase
         if ($urandom_range(7, 0) == 0) len = ($urandom_range(1, 0) != 0) ? 8'd255
                                                                       : 8'($urandom_range(254, 13));
         else len = 8'($urandom_range(6, 0));
         csr_write(REG_PREAMBLE_COUNT, {59'd0, pre});
         csr_write(REG_LONG_ADDRESS, 64'($urandom_range(1, 0)));
         csr_write(REG_SHORT_ADDRESS, 64'($urandom_range(255, 0)));
         csr_write(REG_UNIQUE_ID, {24'd0, 8'($urandom), 32'($urandom)});
         csr_write(REG_COMMAND_CODE, 64'($urandom_range(255, 0)));
         csr_write(REG_PRIMARY_MASTER, 64'($urandom_range(1, 0)));
         csr_write(REG_BURST_FRAME, 64'($urandom_range(1, 0)));
         csr_write(REG_PAYLOAD_LENGTH, {56'd0, len});
         repeat ($urandom_range(3, 1)) begin
            if ($urandom_range(7, 0) == 0) send_word(CMD_DATA, 8'($urandom));
            send_word(CMD_START, 8'($urandom));
            n = int'(shadow_cfg.payload_length);
            if (n > 12) n = $urandom_range(6, 0);
            else if (n > 0 && $urandom_range(7, 0) == 0) n = $urandom_range(n - 1, 0);
            repeat (n) send_word(CMD_DATA, 8'($urandom));
         end
         wait_drained();
      end
      idle_off = 1'b0;
   endtask

   initial begin
      shadow_cfg = '0;
      shadow_cfg.preamble_count = 5'd5;
      shadow_cfg.primary_master = 1'b1;
      frame_sum  = '0;
      bytes_left = '0;
      frame_open = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_register_readback();
      test_short_address();
      test_long_address();
      test_restart_in_frame();
      test_length_latch();
      test_backpressure();
      test_random_frames();
      wait_drained();
      test_register_readback();
      $display("sent %0d request words (%0d producing output), %0d register writes, %0d reads",
               items_sent, active_items, csr_writes, csr_reads);
      $display("checked %0d response words closing %0d frames, %0d mismatches",
               words_seen, frames_seen, mismatches);
      if (mismatches == 0 && frame_bytes.size() == 0) begin
         $display("PASS hart_request_frame_encoder_core");
      end else begin
         $display("FAIL hart_request_frame_encoder_core");
      end
      $finish;
   end

endmodule
